>>> rtl/escf_pkg.sv
`default_nettype none
package escf_pkg;

  // fixed field widths of the item channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned FEAT_W   = 2;
  localparam int unsigned KPOS_W   = 3;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned POT_W    = 32;
  localparam int unsigned MASK_W   = 25;
  localparam int unsigned MIDX_W   = 5;

  // widest addresses over the whole parameter range
  localparam int unsigned POT_AW_MAX = 19;
  localparam int unsigned WGT_AW_MAX = 9;

  localparam logic [CMD_W-1:0] CMD_SPIKE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SIZE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // shared control from the sequencer to every feature bank
  typedef struct packed {
    logic                    rd_en;
    logic [POT_AW_MAX-1:0]   pot_addr;
    logic [WGT_AW_MAX-1:0]   w_addr;
    logic                    upd_en;
    logic [POT_AW_MAX-1:0]   upd_addr;
    logic                    use_w;
    logic [MIDX_W-1:0]       bit_idx;
    logic                    start;
    logic                    clr_en;
    logic [POT_AW_MAX-1:0]   clr_addr;
    logic [WGT_AW_MAX-1:0]   w_waddr;
    logic signed [WGT_W-1:0] w_wdata;
  } bank_ctl_t;

endpackage
`default_nettype wire

>>> rtl/escf_ifs.sv
`default_nettype none
interface escf_in_if;
  import escf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [TIME_W-1:0]        spike_time;
  logic                     scale;
  logic [POS_W-1:0]         row;
  logic [POS_W-1:0]         col;
  logic [FEAT_W-1:0]        in_feature;
  logic [FEAT_W-1:0]        out_feature;
  logic [KPOS_W-1:0]        kernel_row;
  logic [KPOS_W-1:0]        kernel_col;
  logic signed [WGT_W-1:0]  weight_value;
  modport source (output valid, cmd, spike_time, scale, row, col, in_feature, out_feature,
                  kernel_row, kernel_col, weight_value, input ready);
  modport sink (input valid, cmd, spike_time, scale, row, col, in_feature, out_feature,
                kernel_row, kernel_col, weight_value, output ready);
endinterface

interface escf_out_if;
  import escf_pkg::*;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  fire_time;
  logic               fire_scale;
  logic [FEAT_W-1:0]  fire_feature;
  logic [POS_W-1:0]   center_row;
  logic [POS_W-1:0]   center_col;
  logic [MASK_W-1:0]  fire_mask;
  logic               last_of_run;
  modport source (output valid, fire_time, fire_scale, fire_feature, center_row, center_col,
                  fire_mask, last_of_run, input ready);
  modport sink (input valid, fire_time, fire_scale, fire_feature, center_row, center_col,
                fire_mask, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/escf_bank.sv
`default_nettype none
module escf_bank import escf_pkg::*; #(
  parameter int unsigned Depth  = 8192,
  parameter int unsigned WDepth = 100
) (
  input  wire logic                     clk_i,
  input  wire bank_ctl_t                ctl_i,
  input  wire logic signed [POT_W-1:0]  thr_i,
  input  wire logic                     w_we_i,
  output logic [MASK_W-1:0]             mask_o
);
  localparam int unsigned AW  = $clog2(Depth);
  localparam int unsigned WAW = $clog2(WDepth);

  // word: fired mark on top of the potential
  logic [POT_W:0]          pot_mem [Depth];
  logic signed [WGT_W-1:0] w_mem   [WDepth];
  logic [POT_W:0]          rd_q;
  logic signed [WGT_W-1:0] w_q;
  logic [MASK_W-1:0]       mask_q;

  logic signed [WGT_W-1:0] w_use;
  logic signed [POT_W+1:0] sum;
  logic signed [POT_W-1:0] sat;
  logic                    fire;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= pot_mem[ctl_i.pot_addr[AW-1:0]];
      w_q  <= w_mem[ctl_i.w_addr[WAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      w_mem[ctl_i.w_waddr[WAW-1:0]] <= ctl_i.w_wdata;
    end
  end

  always_comb begin
    w_use = ctl_i.use_w ? w_q : '0;
    sum   = {{2{rd_q[POT_W-1]}}, rd_q[POT_W-1:0]} + {{16{w_use[WGT_W-1]}}, w_use, 2'b00};
    if (!sum[POT_W+1] && (sum[POT_W:POT_W-1] != 2'b00)) begin
      sat = {1'b0, {(POT_W-1){1'b1}}};
    end else if (sum[POT_W+1] && (sum[POT_W:POT_W-1] != 2'b11)) begin
      sat = {1'b1, {(POT_W-1){1'b0}}};
    end else begin
      sat = sum[POT_W-1:0];
    end
    fire = !rd_q[POT_W] && (sat >= thr_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_en) begin
      pot_mem[ctl_i.clr_addr[AW-1:0]] <= '0;
    end else if (ctl_i.upd_en) begin
      pot_mem[ctl_i.upd_addr[AW-1:0]] <= {rd_q[POT_W] | fire, sat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      mask_q <= '0;
    end else if (ctl_i.upd_en && fire) begin
      mask_q[ctl_i.bit_idx] <= 1'b1;
    end
  end

  assign mask_o = mask_q;
endmodule
`default_nettype wire

>>> rtl/event_spiking_conv_fire.sv
// spike: accepted in idle, then the walk visits each window position (WIN*WIN) in turn, a drain
// state follows, then results are handed out in turn per output feature, stalling while the
// output is not ready; each window position is read through the single read port of each feature bank
// load, set size: take effect as the item is accepted; clear: accepted, then a sweep over
// NUM_SCALES*MAX_DIM*MAX_DIM bank addresses clears the banks
// reset: same sweep as clear runs first, no item accepted until it ends
// threshold resets to 1.0 in Q15.16, map sizes to min(64, MAX_DIM)
`default_nettype none
module event_spiking_conv_fire import escf_pkg::*; #(
  parameter int unsigned KERNEL_SIZE     = 5,
  parameter int unsigned NUM_FEATURES    = 4,
  parameter int unsigned NUM_IN_FEATURES = 4,
  parameter int unsigned MAX_DIM         = 64,
  parameter int unsigned NUM_SCALES      = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [POT_W-1:0]  cfg_wdata_i,
  escf_in_if.sink                spk_i,
  escf_out_if.source             fire_o
);
  localparam int unsigned HALF      = KERNEL_SIZE / 2;
  localparam int unsigned WIN       = 2 * HALF + 1;
  localparam int unsigned WW        = $clog2(WIN);
  localparam int unsigned BANK_DEPTH = NUM_SCALES * MAX_DIM * MAX_DIM;
  localparam int unsigned BAW       = $clog2(BANK_DEPTH);
  localparam int unsigned WDEPTH    = NUM_IN_FEATURES * KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned FW        = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned RESET_DIM = (MAX_DIM < 64) ? MAX_DIM : 64;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // threshold register
  logic signed [POT_W-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= POT_W'(65536);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  logic acc;
  assign spk_i.ready = (state_q == ST_IDLE);
  assign acc = spk_i.valid && spk_i.ready;

  logic spike_go, load_go, size_go, clear_go;
  assign spike_go = acc && (spk_i.cmd == CMD_SPIKE) && (int'(spk_i.scale) < NUM_SCALES)
                    && (int'(spk_i.in_feature) < NUM_IN_FEATURES);
  assign load_go  = acc && (spk_i.cmd == CMD_LOAD)
                    && (int'(spk_i.out_feature) < NUM_FEATURES)
                    && (int'(spk_i.in_feature) < NUM_IN_FEATURES)
                    && (int'(spk_i.kernel_row) < KERNEL_SIZE)
                    && (int'(spk_i.kernel_col) < KERNEL_SIZE);
  assign size_go  = acc && (spk_i.cmd == CMD_SIZE) && (int'(spk_i.scale) < NUM_SCALES);
  assign clear_go = acc && (spk_i.cmd == CMD_CLEAR);

  // per-scale map size, both possible scale codes kept
  logic [DIM_W-1:0] rows_q [2];
  logic [DIM_W-1:0] cols_q [2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        rows_q[s] <= DIM_W'(RESET_DIM);
        cols_q[s] <= DIM_W'(RESET_DIM);
      end
    end else if (size_go) begin
      rows_q[spk_i.scale] <= (int'(spk_i.row) + 1 > MAX_DIM) ? DIM_W'(MAX_DIM)
                                                             : DIM_W'(int'(spk_i.row) + 1);
      cols_q[spk_i.scale] <= (int'(spk_i.col) + 1 > MAX_DIM) ? DIM_W'(MAX_DIM)
                                                             : DIM_W'(int'(spk_i.col) + 1);
    end
  end

  // latched spike
  logic [TIME_W-1:0] tim_q;
  logic              scl_q;
  logic [POS_W-1:0]  row_q, col_q;
  logic [FEAT_W-1:0] inf_q;
  always_ff @(posedge clk_i) begin
    if (spike_go) begin
      tim_q <= spk_i.spike_time;
      scl_q <= spk_i.scale;
      row_q <= spk_i.row;
      col_q <= spk_i.col;
      inf_q <= spk_i.in_feature;
    end
  end

  // window walk counters and clear sweep
  logic [WW-1:0]     dr_q, dc_q;
  logic [MIDX_W-1:0] bit_q;
  logic [BAW-1:0]    clr_q;
  logic [FW-1:0]     f_q;
  logic              walk_end, clr_end, f_end;
  assign walk_end = (dr_q == WW'(WIN - 1)) && (dc_q == WW'(WIN - 1));
  assign clr_end  = (clr_q == BAW'(BANK_DEPTH - 1));
  assign f_end    = (f_q == FW'(NUM_FEATURES - 1));

  // window position under issue
  logic [9:0] r_u, c_u;
  logic       in_map, use_w;
  int         ki, kj;
  logic [BAW-1:0] pot_addr;
  logic [WGT_AW_MAX-1:0] w_addr;
  always_comb begin
    r_u    = 10'(row_q) + 10'(dr_q) - 10'(HALF);
    c_u    = 10'(col_q) + 10'(dc_q) - 10'(HALF);
    // negative offsets wrap far above any map size
    in_map = (r_u < 10'(rows_q[scl_q])) && (c_u < 10'(cols_q[scl_q]));
    ki     = 2 * HALF - int'(dr_q);
    kj     = 2 * HALF - int'(dc_q);
    use_w  = (ki < KERNEL_SIZE) && (kj < KERNEL_SIZE);
    pot_addr = BAW'((int'(scl_q) * MAX_DIM + int'(r_u[7:0])) * MAX_DIM + int'(c_u[7:0]));
    w_addr   = use_w ? WGT_AW_MAX'((int'(inf_q) * KERNEL_SIZE + ki) * KERNEL_SIZE + kj) : '0;
  end

  // read-modify-write stage: banks get read data in the cycle after issue
  logic                  s1_v_q, s1_w_q;
  logic [BAW-1:0]        s1_addr_q;
  logic [MIDX_W-1:0]     s1_bit_q;
  logic                  issue;
  assign issue = (state_q == ST_WALK) && in_map;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_w_q    <= use_w;
    s1_addr_q <= pot_addr;
    s1_bit_q  <= bit_q;
  end

  bank_ctl_t ctl;
  always_comb begin
    ctl          = '0;
    ctl.rd_en    = issue;
    ctl.pot_addr = POT_AW_MAX'(pot_addr);
    ctl.w_addr   = w_addr;
    ctl.upd_en   = s1_v_q;
    ctl.upd_addr = POT_AW_MAX'(s1_addr_q);
    ctl.use_w    = s1_w_q;
    ctl.bit_idx  = s1_bit_q;
    ctl.start    = spike_go;
    ctl.clr_en   = (state_q == ST_CLEAR);
    ctl.clr_addr = POT_AW_MAX'(clr_q);
    ctl.w_waddr  = WGT_AW_MAX'((int'(spk_i.in_feature) * KERNEL_SIZE + int'(spk_i.kernel_row))
                               * KERNEL_SIZE + int'(spk_i.kernel_col));
    ctl.w_wdata  = spk_i.weight_value;
  end

  // one bank per output feature, all walking the same window in lockstep
  logic [MASK_W-1:0] mask [NUM_FEATURES];
  for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_bank
    escf_bank #(
      .Depth  (BANK_DEPTH),
      .WDepth (WDEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .thr_i  (thr_q),
      .w_we_i (load_go && (int'(spk_i.out_feature) == g)),
      .mask_o (mask[g])
    );
  end

  // result output register
  logic              out_v_q, out_load, slot_free, more;
  logic [FEAT_W-1:0] out_f_q;
  logic [MASK_W-1:0] out_mask_q;
  logic              out_last_q;
  logic [TIME_W-1:0] out_tim_q;
  logic              out_scl_q;
  logic [POS_W-1:0]  out_row_q, out_col_q;
  assign slot_free = !out_v_q || fire_o.ready;
  assign out_load  = (state_q == ST_EMIT) && slot_free && (mask[f_q] != '0);

  // later features that still have a result make this one not the last
  always_comb begin
    more = 1'b0;
    for (int g = 0; g < NUM_FEATURES; g++) begin
      if ((g > int'(f_q)) && (mask[g] != '0)) begin
        more = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= (out_v_q && !fire_o.ready) || out_load;
    end
  end

  // spike fields copied with the result, a new spike may be taken while it waits
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_f_q    <= FEAT_W'(f_q);
      out_mask_q <= mask[f_q];
      out_last_q <= !more;
      out_tim_q  <= tim_q;
      out_scl_q  <= scl_q;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
    end
  end

  assign fire_o.valid        = out_v_q;
  assign fire_o.fire_time    = out_tim_q;
  assign fire_o.fire_scale   = out_scl_q;
  assign fire_o.fire_feature = out_f_q;
  assign fire_o.center_row   = out_row_q;
  assign fire_o.center_col   = out_col_q;
  assign fire_o.fire_mask    = out_mask_q;
  assign fire_o.last_of_run  = out_last_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_end) state_d = ST_IDLE;
      ST_IDLE: begin
        if (clear_go) begin
          state_d = ST_CLEAR;
        end else if (spike_go) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK:  if (walk_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT:  if (slot_free && f_end) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      dr_q    <= '0;
      dc_q    <= '0;
      bit_q   <= '0;
      f_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_end ? '0 : clr_q + 1'b1;
      end
      if (spike_go) begin
        dr_q  <= '0;
        dc_q  <= '0;
        bit_q <= '0;
        f_q   <= '0;
      end else if (state_q == ST_WALK) begin
        bit_q <= bit_q + 1'b1;
        if (dc_q == WW'(WIN - 1)) begin
          dc_q <= '0;
          dr_q <= dr_q + 1'b1;
        end else begin
          dc_q <= dc_q + 1'b1;
        end
      end else if ((state_q == ST_EMIT) && slot_free && !f_end) begin
        f_q <= f_q + 1'b1;
      end
    end
  end

  // checks
  a_clear_enters_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_go |=> (state_q == ST_CLEAR))
    else $error("clear item did not start the sweep");

  a_spike_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spike_go |=> (state_q == ST_WALK))
    else $error("spike item did not start the window walk");

  a_update_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> ($past(state_q) == ST_WALK))
    else $error("bank update without a read issued in the walk");

  a_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_EMIT) && !ctl.upd_en)
    else $error("result loaded outside the emit phase");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !acc && !ctl.clr_en)
    else $error("item accepted during a window walk");
endmodule
`default_nettype wire
